FILE: rtl/plst_pkg.sv
// Shared constants for the positional list store: data width, operation and status codes.
package plst_pkg;

    localparam int DATA_W = 32;

    // Operation kinds
    localparam logic [2:0] K_INSERT = 3'd0;
    localparam logic [2:0] K_DELETE = 3'd1;
    localparam logic [2:0] K_LOCATE = 3'd2;
    localparam logic [2:0] K_ERASE  = 3'd3;
    localparam logic [2:0] K_REMOVE = 3'd4;
    localparam logic [2:0] K_DEDUPE = 3'd5;
    localparam logic [2:0] K_CLEAR  = 3'd6;

    // Result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_BADPOS = 2'd2;

endpackage

FILE: rtl/positional_list_store.sv
// Top level of the positional list store: sequencer and shared compare/copy datapath.
//
// Usage: present i_kind, i_value and i_position with start high; the item transfers
// at the rising edge where start is high and busy is low. One result per item is
// shown on o_status, o_found, o_found_position and o_entry_count for exactly one
// cycle, marked by o_result_valid; the receiver cannot stall it.
// Clear, error cases and the unused kind finish at once: the result strobe comes
// in the cycle after the transfer and busy stays low, so these may follow each
// cycle. The other kinds stream the entries through the memory's single read port
// and one 32-bit equality compare, one entry per cycle:
//   insert:  shift up, then write the new value
//   delete:  shift down
//   locate, erase, remove all: one pass over the entries (locate stops at a hit)
//   dedupe:  per kept entry, a key read plus one pass over the entries after it.
// Reset (synchronous, active low) empties the list; the entry memory needs no
// clearing, since only entries below the count are ever read.
module positional_list_store
    import plst_pkg::*;
#(
    parameter int CAPACITY = 128
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [2:0]               i_kind,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic [7:0]               i_position,
    output logic                     o_result_valid,
    output logic [1:0]               o_status,
    output logic                     o_found,
    output logic [7:0]               o_found_position,
    output logic [7:0]               o_entry_count
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = ((CNT_W > 8) ? CNT_W : 8) + 1;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_SHIFT = 6'b000100,
        S_INSWR = 6'b001000,
        S_DKEY  = 6'b010000,
        S_DWAIT = 6'b100000
    } t_state;

    t_state             r_state;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_rd;
    logic [CNT_W-1:0]   r_wr;
    logic [CNT_W-1:0]   r_lo;
    logic [CNT_W-1:0]   r_di;
    logic [IDX_W-1:0]   r_pidx;
    logic               r_pv;
    logic               r_hit;
    logic [2:0]         r_kind;
    logic [DATA_W-1:0]  r_key;
    logic               r_ov;
    logic [1:0]         r_status;
    logic               r_found;
    logic [7:0]         r_fpos;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [DATA_W-1:0]  ram_wdata;
    logic               ram_re;
    logic [IDX_W-1:0]   ram_raddr;
    logic [DATA_W-1:0]  rd_data;

    logic [CMP_W-1:0]   pos_x;
    logic [CMP_W-1:0]   cnt_x;
    logic [CMP_W-1:0]   pos_m1_x;
    logic [CMP_W-1:0]   pidx_p1_x;
    logic [CMP_W-1:0]   cnt_p1_x;
    logic [CNT_W-1:0]   pos_m1;
    logic [CNT_W-1:0]   rd_m1;
    logic               is_full;
    logic               ins_ok;
    logic               del_ok;
    logic               issue_up;
    logic               issue_dn;
    logic               match;
    logic               keep;
    logic               is_locate;

    // Position and count checks, widened so no compare wraps
    assign pos_x     = CMP_W'(i_position);
    assign cnt_x     = CMP_W'(r_count);
    assign pos_m1_x  = pos_x - CMP_W'(1);
    assign pos_m1    = pos_m1_x[CNT_W-1:0];
    assign pidx_p1_x = CMP_W'(r_pidx) + CMP_W'(1);
    assign cnt_p1_x  = cnt_x + CMP_W'(1);
    assign is_full   = (cnt_x >= CMP_W'(CAPACITY));
    assign ins_ok    = (i_position != 8'd0) && (pos_x <= cnt_p1_x);
    assign del_ok    = (i_position != 8'd0) && (pos_x <= cnt_x);

    // Stream control and the shared compare
    assign rd_m1     = r_rd - CNT_W'(1);
    assign issue_up  = (r_rd < r_count);
    assign issue_dn  = (r_rd > r_lo);
    assign match     = (rd_data == r_key);
    assign is_locate = (r_kind == K_LOCATE);
    assign keep      = (r_kind == K_DELETE) || !match || ((r_kind == K_ERASE) && r_hit);

    assign busy             = (r_state != S_IDLE);
    assign o_result_valid   = r_ov;
    assign o_status         = r_status;
    assign o_found          = r_found;
    assign o_found_position = r_fpos;
    assign o_entry_count    = cnt_x[7:0];

    // Memory port drive per state
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_wr[IDX_W-1:0];
        ram_wdata = rd_data;
        ram_re    = 1'b0;
        ram_raddr = r_rd[IDX_W-1:0];
        unique case (r_state)
            S_SCAN: begin
                ram_re = issue_up;
                ram_we = r_pv && keep && !is_locate;
            end
            S_SHIFT: begin
                ram_re    = issue_dn;
                ram_raddr = rd_m1[IDX_W-1:0];
                ram_we    = r_pv;
                ram_waddr = r_pidx + IDX_W'(1);
            end
            S_INSWR: begin
                ram_we    = 1'b1;
                ram_waddr = r_lo[IDX_W-1:0];
                ram_wdata = r_key;
            end
            S_DKEY: begin
                ram_re    = (r_di < r_count);
                ram_raddr = r_di[IDX_W-1:0];
            end
            default: begin
            end
        endcase
    end

    plst_ram #(
        .DEPTH (CAPACITY),
        .IDX_W (IDX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (rd_data)
    );

    // Control state: reset clears it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ov    <= 1'b0;
            r_pv    <= 1'b0;
        end else begin
            r_ov <= 1'b0;
            r_pv <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        unique case (i_kind)
                            K_INSERT: begin
                                if (is_full || !ins_ok) begin
                                    r_ov <= 1'b1;
                                end else begin
                                    r_state <= S_SHIFT;
                                end
                            end
                            K_DELETE: begin
                                if (!del_ok) begin
                                    r_ov <= 1'b1;
                                end else begin
                                    r_state <= S_SCAN;
                                end
                            end
                            K_LOCATE, K_ERASE, K_REMOVE: r_state <= S_SCAN;
                            K_DEDUPE: r_state <= S_DKEY;
                            K_CLEAR: begin
                                r_count <= '0;
                                r_ov    <= 1'b1;
                            end
                            default: r_ov <= 1'b1;
                        endcase
                    end
                end
                S_SCAN: begin
                    r_pv <= issue_up;
                    if (r_pv && is_locate && match) begin
                        r_ov    <= 1'b1;
                        r_state <= S_IDLE;
                    end else if (!issue_up && !r_pv) begin
                        if (is_locate) begin
                            r_ov    <= 1'b1;
                            r_state <= S_IDLE;
                        end else if (r_kind == K_DEDUPE) begin
                            r_count <= r_wr;
                            r_state <= S_DKEY;
                        end else begin
                            r_count <= r_wr;
                            r_ov    <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_SHIFT: begin
                    r_pv <= issue_dn;
                    if (!issue_dn && !r_pv) begin
                        r_state <= S_INSWR;
                    end
                end
                S_INSWR: begin
                    r_count <= r_count + CNT_W'(1);
                    r_ov    <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_DKEY: begin
                    if (r_di < r_count) begin
                        r_state <= S_DWAIT;
                    end else begin
                        r_ov    <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_DWAIT: r_state <= S_SCAN;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath registers: pointers, key and result fields
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    r_kind   <= i_kind;
                    r_key    <= i_value;
                    r_hit    <= 1'b0;
                    r_found  <= 1'b0;
                    r_fpos   <= 8'd0;
                    r_status <= ST_OK;
                    r_rd     <= '0;
                    r_wr     <= '0;
                    r_di     <= '0;
                    r_lo     <= pos_m1;
                    unique case (i_kind)
                        K_INSERT: begin
                            if (is_full) begin
                                r_status <= ST_FULL;
                            end else if (!ins_ok) begin
                                r_status <= ST_BADPOS;
                            end
                            r_rd <= r_count;
                        end
                        K_DELETE: begin
                            if (!del_ok) begin
                                r_status <= ST_BADPOS;
                            end
                            r_rd <= pos_x[CNT_W-1:0];
                            r_wr <= pos_m1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                r_pidx <= r_rd[IDX_W-1:0];
                if (issue_up) begin
                    r_rd <= r_rd + CNT_W'(1);
                end
                if (r_pv && is_locate && match) begin
                    r_found <= 1'b1;
                    r_fpos  <= pidx_p1_x[7:0];
                end else if (r_pv && !is_locate) begin
                    if (keep) begin
                        r_wr <= r_wr + CNT_W'(1);
                    end
                    if (match) begin
                        r_hit <= 1'b1;
                    end
                end
                if (!issue_up && !r_pv) begin
                    // only a locate miss reports count + 1; other kinds keep zero
                    if (is_locate) begin
                        r_fpos <= cnt_p1_x[7:0];
                    end
                    r_di <= r_di + CNT_W'(1);
                end
            end
            S_SHIFT: begin
                r_pidx <= rd_m1[IDX_W-1:0];
                if (issue_dn) begin
                    r_rd <= rd_m1;
                end
            end
            S_DWAIT: begin
                r_key <= rd_data;
                r_rd  <= r_di + CNT_W'(1);
                r_wr  <= r_di + CNT_W'(1);
                r_hit <= 1'b0;
            end
            default: begin
            end
        endcase
    end

`ifndef SYNTHESIS
    // The count never passes the capacity
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cnt_x <= CMP_W'(CAPACITY))
        else $error("entry count above capacity");

    // A result is only shown while the block is idle
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result strobe while busy");

    // An accepted item either starts work or reports at once
    a_accept_reacts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_result_valid))
        else $error("accepted item produced neither work nor a result");

    // Compaction never writes ahead of its read pointer
    a_wr_behind_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_wr <= r_rd))
        else $error("write pointer passed read pointer");

    // A found value always comes with an ok status
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_found) |-> (o_status == ST_OK))
        else $error("found flag with error status");
`endif

endmodule

FILE: rtl/plst_ram.sv
// Entry memory of the list store: one write port, one registered read port.
module plst_ram
    import plst_pkg::*;
#(
    parameter int DEPTH = 128,
    parameter int IDX_W = 7
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [IDX_W-1:0]  i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [IDX_W-1:0]  i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

FILE: sim/tb_positional_list_store.sv
// Self-checking testbench for positional_list_store: directed and random list operations.
`timescale 1ns / 100ps

module tb_positional_list_store;
    import plst_pkg::*;

    localparam int CAPACITY = 128;
    // Kind 7 is unused by the block and must act as a no-op
    localparam logic [2:0] K_UNUSED = 3'd7;
    localparam int IDLE_PCT = 32;

    typedef struct {
        logic [2:0]               kind;
        logic signed [DATA_W-1:0] value;
        logic [7:0]               position;
    } list_op_t;

    typedef struct packed {
        logic [1:0] status;
        logic       found;
        logic [7:0] found_position;
        logic [7:0] entry_count;
    } list_result_t;

    typedef enum int {MODE_FILL, MODE_MIX, MODE_DRAIN} gen_mode_e;

    logic                     i_clk;
    logic                     i_rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic [2:0]               i_kind = K_CLEAR;
    logic signed [DATA_W-1:0] i_value = '0;
    logic [7:0]               i_position = '0;
    logic                     o_result_valid;
    logic [1:0]               o_status;
    logic                     o_found;
    logic [7:0]               o_found_position;
    logic [7:0]               o_entry_count;

    // Shadow copy of the list contents and length
    logic signed [DATA_W-1:0] shadow_list [CAPACITY];
    int                       shadow_count = 0;

    list_op_t     pending_ops [$];
    list_result_t expected_results [$];
    int           mismatch_count = 0;
    int           result_index = 0;
    int           cycle_count = 0;
    int           cycle_limit = 20000;
    bit           no_gaps = 1'b0;

    positional_list_store #(
        .CAPACITY(CAPACITY)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_kind          (i_kind),
        .i_value         (i_value),
        .i_position      (i_position),
        .o_result_valid  (o_result_valid),
        .o_status        (o_status),
        .o_found         (o_found),
        .o_found_position(o_found_position),
        .o_entry_count   (o_entry_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Close the gap left by the entry at idx
    function automatic void drop_entry(input int idx);
        int k;
        for (k = idx; k < shadow_count - 1; k++) shadow_list[k] = shadow_list[k + 1];
        shadow_count--;
    endfunction

    // Apply one operation to the shadow list and return the result it should give
    function automatic list_result_t predict_list_op(input list_op_t op);
        list_result_t r;
        int pos;
        int idx;
        int keep;
        int k;
        bit dup;
        r = '0;
        r.status = ST_OK;
        pos = op.position;
        case (op.kind)
            K_INSERT: begin
                if (shadow_count >= CAPACITY) begin
                    r.status = ST_FULL;
                end else if (pos < 1 || pos > shadow_count + 1) begin
                    r.status = ST_BADPOS;
                end else begin
                    for (idx = shadow_count; idx >= pos; idx--)
                        shadow_list[idx] = shadow_list[idx - 1];
                    shadow_list[pos - 1] = op.value;
                    shadow_count++;
                end
            end
            K_DELETE: begin
                if (pos < 1 || pos > shadow_count) r.status = ST_BADPOS;
                else drop_entry(pos - 1);
            end
            K_LOCATE, K_ERASE: begin
                idx = 0;
                while (idx < shadow_count && shadow_list[idx] != op.value) idx++;
                if (op.kind == K_LOCATE) begin
                    r.found = (idx < shadow_count);
                    r.found_position = 8'(idx + 1);
                end else if (idx < shadow_count) begin
                    drop_entry(idx);
                end
            end
            K_REMOVE: begin
                keep = 0;
                for (idx = 0; idx < shadow_count; idx++) begin
                    if (shadow_list[idx] != op.value) begin
                        shadow_list[keep] = shadow_list[idx];
                        keep++;
                    end
                end
                shadow_count = keep;
            end
            K_DEDUPE: begin
                // keep an entry only if no earlier kept entry holds the same value
                keep = 0;
                for (idx = 0; idx < shadow_count; idx++) begin
                    dup = 1'b0;
                    for (k = 0; k < keep; k++)
                        if (shadow_list[k] == shadow_list[idx]) dup = 1'b1;
                    if (!dup) begin
                        shadow_list[keep] = shadow_list[idx];
                        keep++;
                    end
                end
                shadow_count = keep;
            end
            K_CLEAR: shadow_count = 0;
            default: ;
        endcase
        r.entry_count = 8'(shadow_count);
        return r;
    endfunction

    // Random operation shaped by the current list length
    function automatic list_op_t gen_random_op(input gen_mode_e mode);
        list_op_t op;
        int roll;
        int span;
        roll = $urandom_range(0, 99);
        case (mode)
            MODE_FILL: begin
                op.kind = (roll < 90) ? K_INSERT : (roll < 95) ? K_LOCATE :
                          (roll < 98) ? K_DELETE : K_ERASE;
            end
            MODE_DRAIN: begin
                op.kind = (roll < 40) ? K_DELETE : (roll < 60) ? K_ERASE :
                          (roll < 72) ? K_REMOVE : (roll < 82) ? K_LOCATE :
                          (roll < 92) ? K_INSERT : (roll < 97) ? K_DEDUPE :
                          (roll < 98) ? K_CLEAR : K_UNUSED;
            end
            default: begin
                op.kind = (roll < 39) ? K_INSERT : (roll < 57) ? K_DELETE :
                          (roll < 73) ? K_LOCATE : (roll < 83) ? K_ERASE :
                          (roll < 90) ? K_REMOVE : (roll < 95) ? K_DEDUPE :
                          (roll < 96) ? K_CLEAR : K_UNUSED;
            end
        endcase

        // mostly legal positions, some just outside, some anywhere in 0..255
        span = (op.kind == K_DELETE) ? shadow_count : shadow_count + 1;
        roll = $urandom_range(0, 99);
        if (roll < 80 && span > 0) op.position = 8'($urandom_range(1, span));
        else if (roll < 85) op.position = 8'd0;
        else if (roll < 90) op.position = 8'(span + 1);
        else op.position = 8'($urandom_range(0, 255));

        // small pool for repeats, copies of stored values, or full-range values
        roll = $urandom_range(0, 99) + ((mode == MODE_FILL) ? 35 : 0);
        if (roll < 45) begin
            case ($urandom_range(0, 7))
                0: op.value = 0;
                1: op.value = 1;
                2: op.value = -1;
                3: op.value = 7;
                4: op.value = -7;
                5: op.value = 42;
                6: op.value = 32'sh8000_0000;
                default: op.value = 32'sh7FFF_FFFF;
            endcase
        end else if (roll < 70 && shadow_count > 0) begin
            op.value = shadow_list[$urandom_range(0, shadow_count - 1)];
        end else begin
            op.value = $urandom;
        end
        return op;
    endfunction

    // Queue one item and widen the timeout by its worst-case cost
    task automatic queue_op(input logic [2:0] k, input logic signed [DATA_W-1:0] v,
                            input logic [7:0] p);
        list_op_t op;
        op.kind = k;
        op.value = v;
        op.position = p;
        pending_ops.push_back(op);
        cycle_limit += 4 * ((k == K_DEDUPE) ? CAPACITY * CAPACITY : 4 * CAPACITY + 32);
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_ops.size() != 0 || start || expected_results.size() != 0);
    endtask

    // Driver: predicts each transfer, then presents the next item or idles
    always @(posedge i_clk) begin
        list_op_t applied;
        list_op_t next_op;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                applied.kind = i_kind;
                applied.value = i_value;
                applied.position = i_position;
                expected_results.push_back(predict_list_op(applied));
            end
            if (!start || !busy) begin
                if (pending_ops.size() != 0 &&
                    (no_gaps || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    next_op = pending_ops.pop_front();
                    start <= 1'b1;
                    i_kind <= next_op.kind;
                    i_value <= next_op.value;
                    i_position <= next_op.position;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare every strobed result with the oldest expectation
    always @(posedge i_clk) begin
        list_result_t want;
        if (i_rst_n && o_result_valid) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with nothing expected",
                                          result_index));
            end else begin
                want = expected_results.pop_front();
                if (o_status !== want.status)
                    report_mismatch($sformatf("result %0d status: expected %0d got %0d",
                                              result_index, want.status, o_status));
                if (o_found !== want.found)
                    report_mismatch($sformatf("result %0d found: expected %0d got %0d",
                                              result_index, want.found, o_found));
                if (o_found_position !== want.found_position)
                    report_mismatch($sformatf("result %0d found_position: expected %0d got %0d",
                                              result_index, want.found_position,
                                              o_found_position));
                if (o_entry_count !== want.entry_count)
                    report_mismatch($sformatf("result %0d entry_count: expected %0d got %0d",
                                              result_index, want.entry_count,
                                              o_entry_count));
            end
            result_index++;
        end
    end

    // Timeout
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= cycle_limit) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        gen_mode_e mode;
        list_op_t op;
        int ph;
        int n;

        // Directed: empty-list errors, extremes, duplicates, every kind
        queue_op(K_DELETE, 0, 8'd1);
        queue_op(K_LOCATE, 5, 8'd0);
        queue_op(K_INSERT, 3, 8'd0);
        queue_op(K_INSERT, 3, 8'd2);
        queue_op(K_INSERT, 32'sh8000_0000, 8'd1);
        queue_op(K_INSERT, 32'sh7FFF_FFFF, 8'd2);
        queue_op(K_INSERT, -1, 8'd1);
        queue_op(K_INSERT, 0, 8'd4);
        queue_op(K_INSERT, 9, 8'd255);
        queue_op(K_LOCATE, 32'sh7FFF_FFFF, 8'd0);
        queue_op(K_LOCATE, 12345, 8'd0);
        queue_op(K_INSERT, -1, 8'd3);
        queue_op(K_INSERT, 32'sh8000_0000, 8'd6);
        queue_op(K_DEDUPE, 0, 8'd0);
        queue_op(K_ERASE, -1, 8'd0);
        queue_op(K_ERASE, 777, 8'd0);
        queue_op(K_INSERT, -5, 8'd1);
        queue_op(K_INSERT, -5, 8'd3);
        queue_op(K_REMOVE, -5, 8'd0);
        queue_op(K_REMOVE, 99, 8'd0);
        queue_op(K_DELETE, 0, 8'd4);
        queue_op(K_DELETE, 0, 8'd255);
        queue_op(K_DELETE, 0, 8'd1);
        queue_op(K_UNUSED, 32'sh5A5A_A5A5, 8'hA5);
        queue_op(K_CLEAR, 0, 8'd0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sender holds off until the directed part has fully drained
        wait_drained();

        // Random phases: fill toward capacity, mix, drain; top up lazily so the
        // generator sees a nearly current list length
        for (ph = 0; ph < 8; ph++) begin
            case (ph)
                1, 4:    mode = MODE_FILL;
                3, 6:    mode = MODE_DRAIN;
                default: mode = MODE_MIX;
            endcase
            no_gaps = (ph == 0);
            for (n = 0; n < 160; n++) begin
                while (pending_ops.size() >= 2) @(negedge i_clk);
                op = gen_random_op(mode);
                queue_op(op.kind, op.value, op.position);
            end
            if (ph == 2 || ph == 5) wait_drained();
        end
        no_gaps = 1'b0;

        wait_drained();
        repeat (4 * CAPACITY) @(posedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
